### hw/rtl/rlad_pkg.sv
// Shared constants, widths and control types for the launch and apogee detector.
`default_nettype none

package rlad_pkg;

    // Default datapath parameters.
    localparam int ADC_BITS_DEF  = 10;
    localparam int FRAC_BITS_DEF = 8;

    // Fixed field widths.
    localparam int FS_W     = 8;
    localparam int MARGIN_W = 16;
    localparam int TARGET_W = 8;
    localparam int PRESS_W  = 21;
    localparam int MAG_W    = 18;
    localparam int CNT_W    = 8;

    // Accelerometer count spans for the two supply modes.
    localparam int SPAN_5V  = 675;
    localparam int SPAN_3V3 = 1023;

    // Saturation limits.
    localparam int MAG_MAX   = 262143;
    localparam int COUNT_MAX = 255;

    // Number of acceleration axes.
    localparam int NUM_AXES = 3;

    // Bits of the larger span; the reciprocal shift is the dividend width plus these.
    localparam int SPAN_BITS = $clog2(SPAN_3V3 + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_G   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_VOLT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFTOFF_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PRESSURE = 3'd4;

    // Register values after reset.
    localparam logic [FS_W-1:0]     RST_FULL_SCALE_G   = 8'd200;
    localparam logic                RST_FIVE_VOLT_MODE = 1'b1;
    localparam logic [MARGIN_W-1:0] RST_LIFTOFF_MARGIN = 16'd768;
    localparam logic [TARGET_W-1:0] RST_RISE_TARGET    = 8'd5;
    localparam logic [PRESS_W-1:0]  RST_START_PRESSURE = 21'd101325;

    // Width of the halved rounding numerator raw * fs * 2^(frac+1) + (span-1)/2.
    function automatic int div_width(input int adc_bits, input int frac_bits);
        return adc_bits + FS_W + frac_bits + 2;
    endfunction

    // Width of the axis quotient, which also bounds the axis magnitude.
    function automatic int quo_width(input int adc_bits, input int frac_bits);
        return div_width(adc_bits, frac_bits) + 1 - SPAN_BITS;
    endfunction

    // Reciprocal of a span, rounded up and scaled so that the truncated product
    // equals the floor quotient for every dividend of div_width bits.
    function automatic longint unsigned recip_of(input int adc_bits, input int frac_bits,
                                                 input int span);
        int shift;
        shift = div_width(adc_bits, frac_bits) + SPAN_BITS;
        return ((64'd1 << shift) + 64'(span) - 64'd1) / 64'(span);
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       sq_mul;
        logic [1:0] axis;
        logic       sq_acc;
        logic       sqrt_step;
        logic       finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/rlad_ctrl.sv
// Sequencing state machine for the launch and apogee detector.
`default_nettype none

module rlad_ctrl #(
    parameter int DIV_STEPS  = rlad_pkg::NUM_AXES,
    parameter int SQRT_STEPS = 20
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output rlad_pkg::cmd_t        cmd,
    input  wire rlad_pkg::status_t status
);

    localparam int CW = $clog2(SQRT_STEPS + 1);
    localparam logic [CW-1:0] DIV_LAST  = CW'(DIV_STEPS - 1);
    localparam logic [CW-1:0] SQRT_LAST = CW'(SQRT_STEPS - 1);
    localparam logic [CW-1:0] SQ_LAST   = CW'(rlad_pkg::NUM_AXES);
    localparam logic [CW-1:0] SQ_AXES   = CW'(rlad_pkg::NUM_AXES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQUARE,
        ST_SQRT,
        ST_FINISH
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;

    // Ready only in idle; a result still waiting at the output holds the sequence in the finish state.
    assign s_ready = (state_reg == ST_IDLE);

    // Command decode from the current state and step counter.
    always_comb begin
        cmd           = '0;
        cmd.axis      = cnt_reg[1:0];
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_SQUARE: begin
                cmd.sq_mul = (cnt_reg < SQ_AXES);
                cmd.sq_acc = (cnt_reg != '0);
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == DIV_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQUARE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SQUARE: begin
                    if (cnt_reg == SQ_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (cnt_reg == SQRT_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (!status.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rlad_datapath.sv
// Datapath: axis scaling by reciprocal multiplication, squaring, square root and flight state.
`default_nettype none

module rlad_datapath #(
    parameter int ADC_BITS  = rlad_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = rlad_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire rlad_pkg::cmd_t                      cmd,
    output rlad_pkg::status_t                        status,
    input  wire logic                                cfg_we,
    input  wire logic [rlad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rlad_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [ADC_BITS-1:0]                 s_accel_x_raw,
    input  wire logic [ADC_BITS-1:0]                 s_accel_y_raw,
    input  wire logic [ADC_BITS-1:0]                 s_accel_z_raw,
    input  wire logic [rlad_pkg::PRESS_W-1:0]        s_pressure_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [rlad_pkg::MAG_W-1:0]               m_accel_magnitude,
    output logic                                     m_launched,
    output logic                                     m_apogee_by_accel,
    output logic                                     m_apogee_by_pressure
);

    localparam int NA   = rlad_pkg::NUM_AXES;
    localparam int RW   = ADC_BITS + rlad_pkg::FS_W;
    localparam int XW   = rlad_pkg::div_width(ADC_BITS, FRAC_BITS);
    localparam int QW   = rlad_pkg::quo_width(ADC_BITS, FRAC_BITS);
    localparam int RCW  = XW + 1;
    localparam int PRW  = XW + RCW;
    localparam int SW   = 2 * QW + 2;
    localparam int RTW  = QW + 1;
    localparam int MGW  = rlad_pkg::MAG_W;
    localparam int MW   = (RTW > MGW) ? RTW : MGW;
    localparam int PW   = rlad_pkg::PRESS_W;
    localparam int CW   = rlad_pkg::CNT_W;

    localparam logic [RCW-1:0] RECIP_5V  =
        RCW'(rlad_pkg::recip_of(ADC_BITS, FRAC_BITS, rlad_pkg::SPAN_5V));
    localparam logic [RCW-1:0] RECIP_3V3 =
        RCW'(rlad_pkg::recip_of(ADC_BITS, FRAC_BITS, rlad_pkg::SPAN_3V3));

    // Configuration and flight state.
    logic [rlad_pkg::FS_W-1:0]     fs_reg;
    logic                          five_v_reg;
    logic [rlad_pkg::MARGIN_W-1:0] margin_reg;
    logic [rlad_pkg::TARGET_W-1:0] target_reg;
    logic                          baseline_reg;
    logic                          launch_reg;
    logic [MGW-1:0]                base_mag_reg;
    logic [PW-1:0]                 min_p_reg;
    logic [CW-1:0]                 rise_cnt_reg;
    logic                          m_valid_reg;

    // Working registers.
    logic [XW-1:0]   x_reg   [NA];
    logic [QW-1:0]   quo_reg [NA];
    logic [PW-1:0]   p_reg;
    logic [2*QW-1:0] sq_reg;
    logic [SW-1:0]   acc_reg;
    logic [QW+1:0]   srem_reg;
    logic [RTW-1:0]  root_reg;
    logic [MGW-1:0]  m_mag_reg;
    logic            m_launched_reg;
    logic            m_apo_acc_reg;
    logic            m_apo_press_reg;

    logic [ADC_BITS-1:0] raw_in [NA];
    logic [RW-1:0]       prod   [NA];
    logic [XW-1:0]       x_in   [NA];
    logic [XW-1:0]       half_span;
    logic [RCW-1:0]      recip_sel;
    logic [PRW-1:0]      qprod;

    logic [QW-1:0]  quo_sel;
    logic [QW:0]    diff;
    logic [QW:0]    diff_neg;
    logic [QW-1:0]  abs_val;

    logic [QW+3:0]  s_trial;
    logic [QW+3:0]  s_cand;
    logic           s_ge;

    logic [MW-1:0]  root_ext;
    logic [MGW-1:0] mag;
    logic [MGW:0]   base_sum;
    logic           launch_next;
    logic           track;
    logic           press_lower;
    logic           cnt_inc;
    logic [CW-1:0]  rise_cnt_next;
    logic           apo_acc_next;
    logic           apo_press_next;

    assign raw_in[0] = s_accel_x_raw;
    assign raw_in[1] = s_accel_y_raw;
    assign raw_in[2] = s_accel_z_raw;

    // Rounding offset and scaled reciprocal for the span of the selected supply mode.
    assign half_span = five_v_reg ? XW'((rlad_pkg::SPAN_5V - 1) / 2)
                                  : XW'((rlad_pkg::SPAN_3V3 - 1) / 2);
    assign recip_sel = five_v_reg ? RECIP_5V : RECIP_3V3;

    // Dividends: the rounding numerator 2 * raw * 2 * fs * 2^frac + span halved. The
    // span is odd, so the floor quotient by the span equals the one by twice the span.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            prod[i] = RW'(raw_in[i]) * RW'(fs_reg);
            x_in[i] = XW'({prod[i], {(FRAC_BITS + 1){1'b0}}}) + half_span;
        end
    end

    // Quotient of the selected lane: product with the reciprocal, upper bits kept.
    assign qprod = PRW'(x_reg[cmd.axis]) * PRW'(recip_sel);

    // Centered axis value and its absolute value for the selected lane.
    always_comb begin
        quo_sel  = quo_reg[cmd.axis];
        diff     = {1'b0, quo_sel} - (QW + 1)'({fs_reg, {FRAC_BITS{1'b0}}});
        diff_neg = (QW + 1)'(0) - diff;
        abs_val  = diff[QW] ? diff_neg[QW-1:0] : diff[QW-1:0];
    end

    // One digit pair of the integer square root.
    always_comb begin
        s_trial = {srem_reg, acc_reg[SW-1 -: 2]};
        s_cand  = (QW + 4)'({root_reg, 2'b01});
        s_ge    = (s_trial >= s_cand);
    end

    // Saturated magnitude and flight state updates.
    always_comb begin
        root_ext       = MW'(root_reg);
        mag            = (root_ext > MW'(rlad_pkg::MAG_MAX)) ? MGW'(rlad_pkg::MAG_MAX)
                                                             : root_ext[MGW-1:0];
        base_sum       = {1'b0, base_mag_reg} + (MGW + 1)'(margin_reg);
        launch_next    = launch_reg | (baseline_reg & ({1'b0, mag} >= base_sum));
        track          = baseline_reg & launch_next;
        press_lower    = (p_reg < min_p_reg);
        cnt_inc        = track & !press_lower & (rise_cnt_reg != CW'(rlad_pkg::COUNT_MAX));
        rise_cnt_next  = rise_cnt_reg + 1'b1;
        apo_acc_next   = track & (mag <= base_mag_reg);
        apo_press_next = cnt_inc & (rise_cnt_next == target_reg);
    end

    // Configuration, flight state and output beat valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg       <= rlad_pkg::RST_FULL_SCALE_G;
            five_v_reg   <= rlad_pkg::RST_FIVE_VOLT_MODE;
            margin_reg   <= rlad_pkg::RST_LIFTOFF_MARGIN;
            target_reg   <= rlad_pkg::RST_RISE_TARGET;
            min_p_reg    <= rlad_pkg::RST_START_PRESSURE;
            baseline_reg <= 1'b0;
            launch_reg   <= 1'b0;
            base_mag_reg <= '0;
            rise_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    rlad_pkg::CFG_FULL_SCALE_G:   fs_reg     <= cfg_wdata[rlad_pkg::FS_W-1:0];
                    rlad_pkg::CFG_FIVE_VOLT_MODE: five_v_reg <= cfg_wdata[0];
                    rlad_pkg::CFG_LIFTOFF_MARGIN: margin_reg <= cfg_wdata[rlad_pkg::MARGIN_W-1:0];
                    rlad_pkg::CFG_RISE_TARGET:    target_reg <= cfg_wdata[rlad_pkg::TARGET_W-1:0];
                    rlad_pkg::CFG_START_PRESSURE: min_p_reg  <= cfg_wdata[PW-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.finish) begin
                if (!baseline_reg) begin
                    baseline_reg <= 1'b1;
                    base_mag_reg <= mag;
                end
                launch_reg <= launch_next;
                if (track && press_lower) begin
                    min_p_reg <= p_reg;
                end
                if (cnt_inc) begin
                    rise_cnt_reg <= rise_cnt_next;
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic working registers and output payload.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < NA; i++) begin
                x_reg[i] <= x_in[i];
            end
            p_reg    <= s_pressure_sample;
            acc_reg  <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg[cmd.axis] <= qprod[PRW-1 -: QW];
        end
        if (cmd.sq_mul) begin
            sq_reg <= (2 * QW)'(abs_val) * (2 * QW)'(abs_val);
        end
        if (cmd.sq_acc) begin
            acc_reg <= acc_reg + SW'(sq_reg);
        end
        if (cmd.sqrt_step) begin
            acc_reg  <= {acc_reg[SW-3:0], 2'b00};
            srem_reg <= s_ge ? (QW + 2)'(s_trial - s_cand) : s_trial[QW+1:0];
            root_reg <= {root_reg[RTW-2:0], s_ge};
        end
        if (cmd.finish) begin
            m_mag_reg       <= mag;
            m_launched_reg  <= launch_next;
            m_apo_acc_reg   <= apo_acc_next;
            m_apo_press_reg <= apo_press_next;
        end
    end

    assign status.out_busy      = m_valid_reg & !m_ready;
    assign m_valid              = m_valid_reg;
    assign m_accel_magnitude    = m_mag_reg;
    assign m_launched           = m_launched_reg;
    assign m_apogee_by_accel    = m_apo_acc_reg;
    assign m_apogee_by_pressure = m_apo_press_reg;

endmodule

`default_nettype wire

### hw/rtl/rocket_launch_apogee_detector_top.sv
// Each input beat runs three reciprocal multiplications (one axis each), the squaring
// and summing of the axes and the digit-pair square root, which yields QW+1 result bits,
// where QW = ADC_BITS + FRAC_BITS + 1; the result beat is then registered at the output.
// The block works on one input beat at a time and takes the next only when back in idle.
// A result left waiting at the output holds off the next input beat.
// Reset is synchronous and active low; it restores the register defaults and
// clears the flight state. No clearing pass is needed.
`default_nettype none

module rocket_launch_apogee_detector_top #(
    parameter int ADC_BITS  = rlad_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = rlad_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rlad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rlad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [ADC_BITS-1:0]             s_accel_x_raw,
    input  wire logic [ADC_BITS-1:0]             s_accel_y_raw,
    input  wire logic [ADC_BITS-1:0]             s_accel_z_raw,
    input  wire logic [rlad_pkg::PRESS_W-1:0]    s_pressure_sample,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rlad_pkg::MAG_W-1:0]           m_accel_magnitude,
    output logic                                 m_launched,
    output logic                                 m_apogee_by_accel,
    output logic                                 m_apogee_by_pressure
);

    localparam int QW = rlad_pkg::quo_width(ADC_BITS, FRAC_BITS);

    rlad_pkg::cmd_t    cmd;
    rlad_pkg::status_t status;

    // Sequencer.
    rlad_ctrl #(
        .DIV_STEPS  (rlad_pkg::NUM_AXES),
        .SQRT_STEPS (QW + 1)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Arithmetic and flight state.
    rlad_datapath #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_accel_x_raw        (s_accel_x_raw),
        .s_accel_y_raw        (s_accel_y_raw),
        .s_accel_z_raw        (s_accel_z_raw),
        .s_pressure_sample    (s_pressure_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_accel_magnitude    (m_accel_magnitude),
        .m_launched           (m_launched),
        .m_apogee_by_accel    (m_apogee_by_accel),
        .m_apogee_by_pressure (m_apogee_by_pressure)
    );

endmodule

`default_nettype wire

### tb/rocket_launch_apogee_detector_top_tb.sv
// Self-checking testbench for the launch and apogee detector: directed flight, then random phases.
module rocket_launch_apogee_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlad_pkg::*;

    localparam int ADC         = ADC_BITS_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int HALF_PERIOD = 5;
    localparam int PRESS_TOP   = 1400000;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [ADC-1:0]     x;
        logic [ADC-1:0]     y;
        logic [ADC-1:0]     z;
        logic [PRESS_W-1:0] pressure;
    } sensor_sample_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             launched;
        logic             apogee_accel;
        logic             apogee_pressure;
    } flight_report_t;

    // Clock, reset and block ports.
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ADC-1:0]        s_accel_x_raw = '0;
    logic [ADC-1:0]        s_accel_y_raw = '0;
    logic [ADC-1:0]        s_accel_z_raw = '0;
    logic [PRESS_W-1:0]    s_pressure_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [MAG_W-1:0]      m_accel_magnitude;
    logic                  m_launched;
    logic                  m_apogee_by_accel;
    logic                  m_apogee_by_pressure;

    // Predictor copy of the registers.
    logic [FS_W-1:0]     cfg_fs        = RST_FULL_SCALE_G;
    logic                cfg_five_volt = RST_FIVE_VOLT_MODE;
    logic [MARGIN_W-1:0] cfg_margin    = RST_LIFTOFF_MARGIN;
    logic [TARGET_W-1:0] cfg_target    = RST_RISE_TARGET;

    // Predictor copy of the flight state.
    logic               baseline_taken = 1'b0;
    logic               flight_launched = 1'b0;
    logic [MAG_W-1:0]   baseline_mag = '0;
    logic [PRESS_W-1:0] min_pressure = RST_START_PRESSURE;
    logic [CNT_W-1:0]   rise_count = '0;

    // Bookkeeping between the stimulus, the driver and the monitor.
    sensor_sample_t sample_queue[$];
    flight_report_t expected_reports[$];
    int             samples_issued = 0;
    int             reports_seen   = 0;
    int             error_count    = 0;
    int             quiet_cycles   = 0;
    int             press_trend    = 0;
    bit             beat_taken     = 1'b0;
    bit             steady         = 1'b0;

    rocket_launch_apogee_detector_top DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_accel_x_raw       (s_accel_x_raw),
        .s_accel_y_raw       (s_accel_y_raw),
        .s_accel_z_raw       (s_accel_z_raw),
        .s_pressure_sample   (s_pressure_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accel_magnitude   (m_accel_magnitude),
        .m_launched          (m_launched),
        .m_apogee_by_accel   (m_apogee_by_accel),
        .m_apogee_by_pressure(m_apogee_by_pressure)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // One axis in signed g with FRAC fraction bits, rounded half up.
    function automatic longint scaled_axis(input logic [ADC-1:0] raw);
        longint unsigned span;
        longint unsigned num;
        span = cfg_five_volt ? SPAN_5V : SPAN_3V3;
        num  = (64'(raw) * 64'(cfg_fs)) << (FRAC + 1);
        return longint'((2 * num + span) / (2 * span)) - (longint'(cfg_fs) << FRAC);
    endfunction

    // Floor square root, one result bit per pass from the top.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] magnitude_of(input logic [ADC-1:0] x,
                                                      input logic [ADC-1:0] y,
                                                      input logic [ADC-1:0] z);
        longint          a;
        longint unsigned sum;
        longint unsigned root;
        a    = scaled_axis(x);
        sum  = a * a;
        a    = scaled_axis(y);
        sum += a * a;
        a    = scaled_axis(z);
        sum += a * a;
        root = floor_root(sum);
        if (root > MAG_MAX)
            return MAG_W'(MAG_MAX);
        return root[MAG_W-1:0];
    endfunction

    // Advances the flight state by one sample and returns the report it should produce.
    function automatic flight_report_t advance_flight(input sensor_sample_t smp);
        flight_report_t rep;
        logic [MAG_W-1:0] mag;
        mag = magnitude_of(smp.x, smp.y, smp.z);
        rep = '0;
        rep.magnitude = mag;
        if (!baseline_taken) begin
            baseline_taken = 1'b1;
            baseline_mag   = mag;
        end else begin
            if (!flight_launched && 32'(mag) >= 32'(baseline_mag) + 32'(cfg_margin))
                flight_launched = 1'b1;
            if (flight_launched) begin
                rep.apogee_accel = (mag <= baseline_mag);
                if (smp.pressure < min_pressure) begin
                    min_pressure = smp.pressure;
                end else if (rise_count != COUNT_MAX) begin
                    rise_count++;
                    rep.apogee_pressure = (rise_count == cfg_target);
                end
            end
        end
        rep.launched = flight_launched;
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Raw counts: near mid scale or anywhere in most cases, at the ends in some.
    function automatic logic [ADC-1:0] pick_raw();
        int unsigned span;
        int unsigned sel;
        span = cfg_five_volt ? SPAN_5V : SPAN_3V3;
        sel  = $urandom_range(99);
        if (sel < 40)
            return ADC'(span / 2 - 3 + $urandom_range(6));
        if (sel < 85)
            return ADC'($urandom_range(1023));
        if (sel < 92)
            return '0;
        return (cfg_five_volt && $urandom_range(1)) ? ADC'(SPAN_5V) : ADC'(1023);
    endfunction

    task automatic send(input logic [ADC-1:0] x, input logic [ADC-1:0] y,
                        input logic [ADC-1:0] z, input int unsigned p);
        sample_queue.push_back('{x: x, y: y, z: z, pressure: p[PRESS_W-1:0]});
        samples_issued++;
    endtask

    // Waits until every issued sample has produced its report.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (reports_seen != samples_issued);
    endtask

    // Register write; the enable stays high across back to back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_FULL_SCALE_G:   cfg_fs        = value[FS_W-1:0];
            CFG_FIVE_VOLT_MODE: cfg_five_volt = value[0];
            CFG_LIFTOFF_MARGIN: cfg_margin    = value[MARGIN_W-1:0];
            CFG_RISE_TARGET:    cfg_target    = value[TARGET_W-1:0];
            CFG_START_PRESSURE: min_pressure  = value[PRESS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input int unsigned fs, input int unsigned five_volt,
                                  input int unsigned margin, input int unsigned target,
                                  input int unsigned start);
        write_reg(CFG_FULL_SCALE_G, fs);
        write_reg(CFG_FIVE_VOLT_MODE, five_volt);
        write_reg(CFG_LIFTOFF_MARGIN, margin);
        write_reg(CFG_RISE_TARGET, target);
        write_reg(CFG_START_PRESSURE, start);
        end_writes();
    endtask

    // A phase of samples; the pressure mostly falls like a descent, with rises,
    // flat stretches and the odd wild reading. Noisy phases are all wild.
    task automatic run_phase(input int n, input bit noisy);
        int roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (noisy || roll < 5)
                press_trend = $urandom_range(PRESS_TOP);
            else if (roll < 15)
                press_trend += $urandom_range(3000);
            else if (roll >= 20)
                press_trend -= $urandom_range(2500, 1);
            if (press_trend < 0)
                press_trend = 0;
            if (press_trend > PRESS_TOP)
                press_trend = PRESS_TOP;
            send(pick_raw(), pick_raw(), pick_raw(), press_trend);
        end
        wait_drained();
    endtask

    // Sample driver: presents the next beat once the current one is taken.
    always @(negedge aclk) begin
        sensor_sample_t nxt;
        if (aresetn && (!s_valid || beat_taken)) begin
            if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
                nxt = sample_queue.pop_front();
                s_valid           <= 1'b1;
                s_accel_x_raw     <= nxt.x;
                s_accel_y_raw     <= nxt.y;
                s_accel_z_raw     <= nxt.z;
                s_pressure_sample <= nxt.pressure;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 15);
    end

    // Monitor: predicts on taken sample beats, checks report beats, and watches for a hang.
    always @(posedge aclk) begin
        flight_report_t want;
        bit             moved;
        beat_taken = 1'b0;
        if (aresetn) begin
            moved = cfg_we;
            // Reports are checked before this edge's sample is predicted.
            if (m_valid && m_ready) begin
                moved = 1'b1;
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected report beat: accel_magnitude %0d", m_accel_magnitude);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("accel_magnitude", want.magnitude, m_accel_magnitude);
                    check_field("launched", want.launched, m_launched);
                    check_field("apogee_by_accel", want.apogee_accel, m_apogee_by_accel);
                    check_field("apogee_by_pressure", want.apogee_pressure,
                                m_apogee_by_pressure);
                end
            end
            if (s_valid && s_ready) begin
                moved      = 1'b1;
                beat_taken = 1'b1;
                expected_reports.push_back(advance_flight('{x: s_accel_x_raw,
                                                           y: s_accel_y_raw,
                                                           z: s_accel_z_raw,
                                                           pressure: s_pressure_sample}));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [MAG_W-1:0] t_mag;
        int unsigned      tgt;
        int unsigned      fs_pick;
        int unsigned      margin_pick;
        int unsigned      start_pick;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Baseline near zero g, then a small reading that must not count as liftoff.
        send(338, 338, 338, 101000);
        send(340, 338, 338, 101400);
        wait_drained();

        // Widest margin: a one-axis full-scale reading still stays on the pad.
        write_reg(CFG_LIFTOFF_MARGIN, 65535);
        end_writes();
        send(0, 338, 338, 101200);
        wait_drained();

        // Liftoff threshold: one count short, then exactly at the margin.
        t_mag = magnitude_of(338, 338, 0);
        write_reg(CFG_LIFTOFF_MARGIN, t_mag - baseline_mag + 1);
        end_writes();
        send(338, 338, 0, 101300);
        wait_drained();
        write_reg(CFG_LIFTOFF_MARGIN, t_mag - baseline_mag);
        end_writes();
        send(338, 338, 0, 101400);

        // In flight: counts at and beyond the span, pressure floor, then a flat
        // run through the rise target and readings back at the baseline.
        send(0, 0, 0, 101300);
        send(1023, 1023, 1023, 0);
        send(0, 1023, 338, 0);
        send(1023, 0, 675, 0);
        send(675, 675, 675, 0);
        send(337, 338, 339, 0);
        send(338, 338, 338, 0);
        send(338, 338, 338, PRESS_TOP);
        send(0, 1023, 0, PRESS_TOP);
        wait_drained();

        // Zero range and a target that can never be met.
        apply_settings(0, 0, 0, 0, PRESS_TOP);
        send(0, 0, 0, PRESS_TOP);
        send(1023, 1023, 1023, PRESS_TOP - 1);
        send(512, 511, 0, PRESS_TOP - 1);
        send(1023, 0, 1023, 700000);
        wait_drained();

        // Random phases, each with its own settings and a reachable rise target.
        for (int ph = 0; ph < 10; ph++) begin
            fs_pick     = (ph % 4 == 0) ? 1 : (ph % 4 == 1) ? 255 : $urandom_range(255, 1);
            margin_pick = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 65535 : $urandom_range(65535);
            start_pick  = (ph == 2) ? PRESS_TOP : $urandom_range(PRESS_TOP, 700000);
            tgt         = rise_count + $urandom_range(12, 1);
            if (tgt > COUNT_MAX)
                tgt = COUNT_MAX;
            apply_settings(fs_pick, ph % 2, margin_pick, tgt, start_pick);
            press_trend = start_pick;
            steady      = (ph == 4);
            run_phase(125, 1'b0);
        end
        steady = 1'b0;

        // Wild pressures from a zero floor drive the rise count into saturation.
        apply_settings(255, 1, $urandom_range(65535), COUNT_MAX, 0);
        press_trend = 0;
        run_phase(180, 1'b1);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
